// ===== design/lol_pkg.sv =====
package lol_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ACT_APPEND      = 3'd0,
    ACT_REMOVE_LAST = 3'd1,
    ACT_INSERT_ORD  = 3'd2,
    ACT_INSERT_AT   = 3'd3,
    ACT_REMOVE_AT   = 3'd4,
    ACT_REMOVE_MEM  = 3'd5,
    ACT_FIND        = 3'd6,
    ACT_CLEAR       = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] word_handle;
    logic [7:0]  word_length;
    logic [5:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  result_position;
    logic [15:0] removed_handle;
    logic [5:0]  entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic apply;
  } dp_cmd_t;

endpackage

// ===== design/length_ordered_entry_list_core.sv =====
// Each accepted item is applied in S_EXEC; its registered result is presented in S_OUT.
// A new item is accepted while idle or while the held result is taken, never during execute.
// Each item is captured, then applied by a parallel compare and shift
// over all list cells.
// Reset (rst, synchronous): list count goes to zero, no result pending.
module length_ordered_entry_list_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lol_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lol_pkg::out_item_t  out_data
);
  import lol_pkg::*;

  dp_cmd_t cmd;

  lol_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  lol_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_data), .out_item(out_data)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_data.entry_count <= 6'(CAPACITY)) else $error("count over capacity");
  a_apply_to_out: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> out_valid) else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> !in_ready) else $error("accept during execute");
`endif

endmodule

// ===== design/lol_ctrl.sv =====
module lol_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lol_pkg::dp_cmd_t cmd
);
  import lol_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  // step through capture, apply, deliver
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = in_valid ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign out_valid = (state == S_OUT);
  assign in_ready  = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.apply = (state == S_EXEC);

endmodule

// ===== design/lol_dp.sv =====
module lol_dp (
  input  logic               clk,
  input  logic               rst,
  input  lol_pkg::dp_cmd_t   cmd,
  input  lol_pkg::in_item_t  in_item,
  output lol_pkg::out_item_t out_item
);
  import lol_pkg::*;

  logic [15:0]      hnd [CAPACITY];
  logic [7:0]       len [CAPACITY];
  logic [CNT_W-1:0] count;
  in_item_t         op;
  out_item_t        res;

  logic [CNT_W-1:0] ord_at, eq_at, at, rm_at;
  logic             full, do_ins, do_rm, found;
  logic [1:0]       st;
  logic [CNT_W-1:0] rpos;
  logic [15:0]      rhnd;
  logic [CNT_W-1:0] pos_w;

  // hold the item
  always_ff @(posedge clk) begin
    if (cmd.load) op <= in_item;
  end

  // priority search for ordered slot and first equal length
  always_comb begin
    ord_at = count;
    eq_at  = count;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count && !(op.word_length > len[i])) ord_at = CNT_W'(i);
      if (CNT_W'(i) < count && op.word_length == len[i]) eq_at = CNT_W'(i);
    end
  end

  // decide the operation
  always_comb begin
    full   = (count >= CNT_W'(CAPACITY));
    found  = (eq_at < count);
    pos_w  = CNT_W'(op.position);
    st     = ST_OK;
    rpos   = '0;
    rhnd   = '0;
    do_ins = 1'b0;
    do_rm  = 1'b0;
    at     = '0;
    rm_at  = '0;
    case (action_t'(op.action))
      ACT_APPEND: if (full) st = ST_FULL; else begin
        at = count; do_ins = 1'b1;
      end
      ACT_REMOVE_LAST: if (count == '0) st = ST_EMPTY; else begin
        rm_at = count - 1'b1; do_rm = 1'b1;
      end
      ACT_INSERT_ORD: if (full) st = ST_FULL; else begin
        at = ord_at; do_ins = 1'b1;
      end
      ACT_INSERT_AT: if (full) st = ST_FULL;
        else if (pos_w > count) st = ST_BAD;
        else begin at = pos_w; do_ins = 1'b1; end
      ACT_REMOVE_AT: if (pos_w >= count) st = ST_BAD; else begin
        rm_at = pos_w; do_rm = 1'b1;
      end
      ACT_REMOVE_MEM: if (count == '0) st = ST_EMPTY;
        else if (!found) st = ST_BAD;
        else begin rm_at = eq_at; do_rm = 1'b1; end
      ACT_FIND: if (!found) st = ST_BAD; else rpos = eq_at;
      default: st = ST_OK;
    endcase
    if (do_ins) rpos = at;
    if (do_rm) begin
      rpos = rm_at;
      rhnd = hnd[rm_at[IDX_W-1:0]];
    end
  end

  // shift the cells and update the count
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) begin
          if (CNT_W'(i) == at) begin
            hnd[i] <= op.word_handle;
            len[i] <= op.word_length;
          end else if (CNT_W'(i) > at && i > 0) begin
            hnd[i] <= hnd[(i > 0) ? i - 1 : 0];
            len[i] <= len[(i > 0) ? i - 1 : 0];
          end
        end else if (do_rm && CNT_W'(i) >= rm_at && i < CAPACITY - 1) begin
          hnd[i] <= hnd[(i < CAPACITY - 1) ? i + 1 : i];
          len[i] <= len[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.apply) begin
      if (action_t'(op.action) == ACT_CLEAR) count <= '0;
      else if (do_ins) count <= count + 1'b1;
      else if (do_rm) count <= count - 1'b1;
    end
  end

  // register the result
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res.status          <= st;
      res.result_position <= rpos[4:0];
      res.removed_handle  <= rhnd;
    end
  end

  assign out_item.status          = res.status;
  assign out_item.result_position = res.result_position;
  assign out_item.removed_handle  = res.removed_handle;
  assign out_item.entry_count     = 6'(count);

endmodule
